// File: rtl/apsp_pkg.sv
// ---------------------------------------------------------------------------
// apsp_pkg: shared types and constants for the graph median block
// Distance width, the saturating infinity value, request kinds, controller
// states and the command word that the controller hands to the datapath.
// ---------------------------------------------------------------------------
package apsp_pkg;

	// Distances saturate at one thousand million, which fits in 30 bits
	localparam int DIST_W = 30;
	localparam logic [DIST_W-1:0] INF_DIST = 30'd1000000000;

	// Row sum accumulator and reported cost width
	localparam int SUM_W = 40;

	// Request kinds; the fourth code is ignored
	typedef enum logic [1:0] {
		KIND_CLEAR = 2'd0,
		KIND_EDGE  = 2'd1,
		KIND_SOLVE = 2'd2
	} kind_t;

	// Controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_EDGE_AB,
		ST_EDGE_BA,
		ST_SOLVE_WAIT,
		ST_FW_DIK,
		ST_FW_RELAX,
		ST_SUM,
		ST_DRAIN
	} state_t;

	// Datapath operations
	typedef enum logic [2:0] {
		OP_NONE,
		OP_CLR_WR,
		OP_EDGE_WR,
		OP_RD_DIK,
		OP_RELAX,
		OP_SUM
	} op_t;

	// Command word from controller to datapath
	typedef struct packed {
		op_t  op;
		logic diag;       // clear write lands on the diagonal
		logic load_w;     // capture the edge weight of the accepted request
		logic row_first;  // first column of a row sum
		logic row_last;   // last column of a row sum
		logic first_row;  // row sum belongs to node zero
		logic last_item;  // final read of the whole solve
	} cmd_t;

endpackage

// File: rtl/apsp_graph_median.sv
// ---------------------------------------------------------------------------
// apsp_graph_median: all-pairs shortest paths and graph median
// Keeps a distance matrix in memory; clears it, loads undirected edges and
// closes it with a pivot sweep, then reports the node with the least row sum.
// ---------------------------------------------------------------------------
//
//  Channel  Dir  Handshake            Payload
//  -------  ---  -------------------  ---------------------------------
//  in       in   in_valid / in_ready  kind, node_a, node_b, weight
//  out      out  out_valid/out_ready  median_node, total_cost
//  cfg      in   cfg_wr_en            cfg_wr_data (node count)
//
// A clear writes all N*N entries, N = 2**clog2(MAX_NODES); a solve works on the
// first n nodes, n the node count clamped to one..MAX_NODES. The single write
// port and two read ports of the matrix memory allow one relaxation or one summed
// entry per cycle along a row; each relaxed row starts with a pivot entry fetch.
// Reset does not touch the matrix; send a clear request before the first solve.
// A solve waits before its pivot sweep while an earlier result is still unread.
// ---------------------------------------------------------------------------
module apsp_graph_median #(
	parameter int MAX_NODES   = 32,
	parameter int WEIGHT_BITS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [1:0]                 kind,
	input  logic [4:0]                 node_a,
	input  logic [4:0]                 node_b,
	input  logic [15:0]                weight,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [4:0]                 median_node,
	output logic [apsp_pkg::SUM_W-1:0] total_cost,
	input  logic                       cfg_wr_en,
	input  logic [5:0]                 cfg_wr_data
);

	localparam int IDX_W  = $clog2(MAX_NODES);
	localparam int ADDR_W = 2 * IDX_W;

	apsp_pkg::cmd_t    cmd;
	logic [ADDR_W-1:0] addr_a;
	logic [ADDR_W-1:0] addr_b;
	logic              out_busy;

	apsp_ctrl #(
		.MAX_NODES (MAX_NODES)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.kind        (kind),
		.node_a      (node_a),
		.node_b      (node_b),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.out_busy    (out_busy),
		.cmd         (cmd),
		.addr_a      (addr_a),
		.addr_b      (addr_b)
	);

	apsp_dpath #(
		.MAX_NODES   (MAX_NODES),
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.addr_a      (addr_a),
		.addr_b      (addr_b),
		.weight      (weight),
		.out_busy    (out_busy),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.median_node (median_node),
		.total_cost  (total_cost)
	);

endmodule

// File: rtl/apsp_ram.sv
// ---------------------------------------------------------------------------
// apsp_ram: generic memory
// One write port and two read ports, read-first, read data registered.
// ---------------------------------------------------------------------------
module apsp_ram #(
	parameter int WIDTH = 30,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr_a,
	output logic [WIDTH-1:0] rd_data_a,
	input  logic [AW-1:0]    rd_addr_b,
	output logic [WIDTH-1:0] rd_data_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered reads
	always_ff @(posedge clk) begin
		rd_data_a <= mem_q[rd_addr_a];
		rd_data_b <= mem_q[rd_addr_b];
	end

endmodule

// File: rtl/apsp_dpath.sv
// ---------------------------------------------------------------------------
// apsp_dpath: distance matrix and arithmetic
// Holds the matrix memory, the relaxation adder and compare, the row sum
// accumulator, the best-row tracker and the result register.
// ---------------------------------------------------------------------------
module apsp_dpath #(
	parameter int MAX_NODES   = 32,
	parameter int WEIGHT_BITS = 16,
	localparam int IDX_W  = $clog2(MAX_NODES),
	localparam int ADDR_W = 2 * IDX_W
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  apsp_pkg::cmd_t             cmd,
	input  logic [ADDR_W-1:0]          addr_a,
	input  logic [ADDR_W-1:0]          addr_b,
	input  logic [15:0]                weight,
	output logic                       out_busy,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [4:0]                 median_node,
	output logic [apsp_pkg::SUM_W-1:0] total_cost
);

	localparam logic [15:0] WMASK = (WEIGHT_BITS >= 16) ? 16'hFFFF :
		16'((32'd1 << WEIGHT_BITS) - 32'd1);

	logic                         wr_en;
	logic [ADDR_W-1:0]            wr_addr;
	logic [apsp_pkg::DIST_W-1:0]  wr_data;
	logic [apsp_pkg::DIST_W-1:0]  rd_data_a;
	logic [apsp_pkg::DIST_W-1:0]  rd_data_b;

	apsp_pkg::cmd_t               cmd_s1;
	logic [ADDR_W-1:0]            addr_s1;
	logic [apsp_pkg::DIST_W-1:0]  dik_q;
	logic [15:0]                  weight_q;
	logic [apsp_pkg::SUM_W-1:0]   row_sum_q;
	logic [apsp_pkg::SUM_W-1:0]   best_cost_q;
	logic [IDX_W-1:0]             best_node_q;
	logic                         out_valid_q;

	logic [apsp_pkg::DIST_W:0]    via;
	logic [apsp_pkg::DIST_W-1:0]  via_sat;
	logic                         better;
	logic [apsp_pkg::SUM_W-1:0]   acc_next;
	logic                         take_row;

	apsp_ram #(
		.WIDTH (apsp_pkg::DIST_W),
		.DEPTH (1 << ADDR_W)
	) u_mat (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_addr_a (addr_a),
		.rd_data_a (rd_data_a),
		.rd_addr_b (addr_b),
		.rd_data_b (rd_data_b)
	);

	// Relax: path through the pivot, saturated at infinity
	always_comb begin
		via = {1'b0, dik_q} + {1'b0, rd_data_a};
		if (via > {1'b0, apsp_pkg::INF_DIST}) begin
			via_sat = apsp_pkg::INF_DIST;
		end else begin
			via_sat = via[apsp_pkg::DIST_W-1:0];
		end
		better = via_sat < rd_data_b;
	end

	// Row sum and best-row compare
	always_comb begin
		acc_next = (cmd_s1.row_first ? '0 : row_sum_q) +
			apsp_pkg::SUM_W'(rd_data_b);
		take_row = cmd_s1.row_last && (cmd_s1.first_row || acc_next < best_cost_q);
	end

	// Memory write: relax results from the read stage, clear and edge writes direct.
	// A 16-bit weight never exceeds infinity, so no clamp is needed.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = addr_b;
		wr_data = apsp_pkg::INF_DIST;
		if (cmd_s1.op == apsp_pkg::OP_RELAX && better) begin
			wr_en   = 1'b1;
			wr_addr = addr_s1;
			wr_data = via_sat;
		end else begin
			case (cmd.op)
				apsp_pkg::OP_CLR_WR: begin
					wr_en   = 1'b1;
					wr_data = cmd.diag ? '0 : apsp_pkg::INF_DIST;
				end
				apsp_pkg::OP_EDGE_WR: begin
					wr_en   = 1'b1;
					wr_data = apsp_pkg::DIST_W'(weight_q & WMASK);
				end
				default: begin
					wr_en = 1'b0;
				end
			endcase
		end
	end

	// Read stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_s1 <= '0;
		end else begin
			cmd_s1 <= cmd;
		end
	end

	// Read stage address and operands
	always_ff @(posedge clk) begin
		addr_s1 <= addr_b;
		if (cmd.load_w) begin
			weight_q <= weight;
		end
		if (cmd_s1.op == apsp_pkg::OP_RD_DIK) begin
			dik_q <= rd_data_a;
		end
	end

	// Accumulate row sums, track the best row, hold the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_sum_q   <= '0;
			best_cost_q <= '1;
			best_node_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd_s1.op == apsp_pkg::OP_SUM) begin
				row_sum_q <= acc_next;
				if (take_row) begin
					best_cost_q <= acc_next;
					best_node_q <= addr_s1[ADDR_W-1:IDX_W];
				end
			end
			if (cmd_s1.op == apsp_pkg::OP_SUM && cmd_s1.last_item) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_busy    = out_valid_q;
	assign out_valid   = out_valid_q;
	assign median_node = 5'(best_node_q);
	assign total_cost  = best_cost_q;

endmodule

// File: rtl/apsp_ctrl.sv
// ---------------------------------------------------------------------------
// apsp_ctrl: request sequencer
// Accepts requests, holds the node count register and walks the clear
// sweep, the mirrored edge writes, the pivot/row/column loops and the row sums.
// ---------------------------------------------------------------------------
module apsp_ctrl #(
	parameter int MAX_NODES = 32,
	localparam int IDX_W  = $clog2(MAX_NODES),
	localparam int ADDR_W = 2 * IDX_W
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          kind,
	input  logic [4:0]          node_a,
	input  logic [4:0]          node_b,
	input  logic                cfg_wr_en,
	input  logic [5:0]          cfg_wr_data,
	input  logic                out_busy,
	output apsp_pkg::cmd_t      cmd,
	output logic [ADDR_W-1:0]   addr_a,
	output logic [ADDR_W-1:0]   addr_b
);

	apsp_pkg::state_t  state_q, state_d;
	logic [5:0]        node_count_q;
	logic [IDX_W-1:0]  k_q, k_d;
	logic [IDX_W-1:0]  i_q, i_d;
	logic [IDX_W-1:0]  j_q, j_d;
	logic [IDX_W-1:0]  nlast_q, nlast_d;
	logic [IDX_W-1:0]  a_q, a_d;
	logic [IDX_W-1:0]  b_q, b_d;
	logic [ADDR_W-1:0] clr_q, clr_d;
	logic [IDX_W-1:0]  nlast_c;
	logic              edge_ok;
	logic              accept;

	// Last node index in use, with the count clamped to one..MAX_NODES
	always_comb begin
		if (node_count_q == '0) begin
			nlast_c = '0;
		end else if (32'(node_count_q) > MAX_NODES) begin
			nlast_c = IDX_W'(MAX_NODES - 1);
		end else begin
			nlast_c = IDX_W'(node_count_q - 6'd1);
		end
	end

	assign edge_ok = (32'(node_a) < MAX_NODES) && (32'(node_b) < MAX_NODES);
	assign accept  = in_valid && in_ready;

	// Next state, counters and commands
	always_comb begin
		state_d  = state_q;
		k_d      = k_q;
		i_d      = i_q;
		j_d      = j_q;
		nlast_d  = nlast_q;
		a_d      = a_q;
		b_d      = b_q;
		clr_d    = clr_q;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.op   = apsp_pkg::OP_NONE;
		addr_a   = '0;
		addr_b   = '0;
		case (state_q)
			apsp_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					case (apsp_pkg::kind_t'(kind))
						apsp_pkg::KIND_CLEAR: begin
							clr_d   = '0;
							state_d = apsp_pkg::ST_CLEAR;
						end
						apsp_pkg::KIND_EDGE: begin
							if (edge_ok) begin
								a_d        = IDX_W'(node_a);
								b_d        = IDX_W'(node_b);
								cmd.load_w = 1'b1;
								state_d    = apsp_pkg::ST_EDGE_AB;
							end
						end
						apsp_pkg::KIND_SOLVE: begin
							nlast_d = nlast_c;
							state_d = apsp_pkg::ST_SOLVE_WAIT;
						end
						default: begin
							state_d = apsp_pkg::ST_IDLE;
						end
					endcase
				end
			end
			// Sweep every address, zero on the diagonal
			apsp_pkg::ST_CLEAR: begin
				cmd.op   = apsp_pkg::OP_CLR_WR;
				cmd.diag = clr_q[ADDR_W-1:IDX_W] == clr_q[IDX_W-1:0];
				addr_b   = clr_q;
				clr_d    = clr_q + 1'b1;
				if (clr_q == '1) begin
					state_d = apsp_pkg::ST_IDLE;
				end
			end
			apsp_pkg::ST_EDGE_AB: begin
				cmd.op  = apsp_pkg::OP_EDGE_WR;
				addr_b  = {a_q, b_q};
				state_d = apsp_pkg::ST_EDGE_BA;
			end
			apsp_pkg::ST_EDGE_BA: begin
				cmd.op  = apsp_pkg::OP_EDGE_WR;
				addr_b  = {b_q, a_q};
				state_d = apsp_pkg::ST_IDLE;
			end
			// Hold until the previous result has been taken
			apsp_pkg::ST_SOLVE_WAIT: begin
				k_d = '0;
				i_d = '0;
				j_d = '0;
				if (!out_busy) begin
					state_d = apsp_pkg::ST_FW_DIK;
				end
			end
			// Fetch the row entry at the pivot column
			apsp_pkg::ST_FW_DIK: begin
				cmd.op  = apsp_pkg::OP_RD_DIK;
				addr_a  = {i_q, k_q};
				j_d     = '0;
				state_d = apsp_pkg::ST_FW_RELAX;
			end
			// Relax one entry per cycle along the row
			apsp_pkg::ST_FW_RELAX: begin
				cmd.op = apsp_pkg::OP_RELAX;
				addr_a = {k_q, j_q};
				addr_b = {i_q, j_q};
				j_d    = j_q + 1'b1;
				if (j_q == nlast_q) begin
					j_d     = '0;
					state_d = apsp_pkg::ST_FW_DIK;
					i_d     = i_q + 1'b1;
					if (i_q == nlast_q) begin
						i_d = '0;
						k_d = k_q + 1'b1;
						if (k_q == nlast_q) begin
							k_d     = '0;
							state_d = apsp_pkg::ST_SUM;
						end
					end
				end
			end
			// Read the closed matrix row by row for the sums
			apsp_pkg::ST_SUM: begin
				cmd.op        = apsp_pkg::OP_SUM;
				addr_b        = {i_q, j_q};
				cmd.row_first = j_q == '0;
				cmd.row_last  = j_q == nlast_q;
				cmd.first_row = i_q == '0;
				cmd.last_item = (i_q == nlast_q) && (j_q == nlast_q);
				j_d           = j_q + 1'b1;
				if (j_q == nlast_q) begin
					j_d = '0;
					i_d = i_q + 1'b1;
					if (i_q == nlast_q) begin
						i_d     = '0;
						state_d = apsp_pkg::ST_DRAIN;
					end
				end
			end
			// Let the last read reach the result register
			apsp_pkg::ST_DRAIN: begin
				state_d = apsp_pkg::ST_IDLE;
			end
			default: begin
				state_d = apsp_pkg::ST_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= apsp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Loop counters and node count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= 6'd32;
			k_q          <= '0;
			i_q          <= '0;
			j_q          <= '0;
			nlast_q      <= '0;
			clr_q        <= '0;
		end else begin
			if (cfg_wr_en) begin
				node_count_q <= cfg_wr_data;
			end
			k_q     <= k_d;
			i_q     <= i_d;
			j_q     <= j_d;
			nlast_q <= nlast_d;
			clr_q   <= clr_d;
		end
	end

	// Edge endpoints
	always_ff @(posedge clk) begin
		if (accept) begin
			a_q <= a_d;
			b_q <= b_d;
		end
	end

endmodule
